// File: hdl/gauss_seidel_solver_top_macros.svh
// assertion macros for the gauss-seidel solver
`ifndef GAUSS_SEIDEL_SOLVER_TOP_MACROS_SVH
`define GAUSS_SEIDEL_SOLVER_TOP_MACROS_SVH
// implication checked on every clock edge outside reset
`define GS_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
// next-cycle implication
`define GS_ASSERT_NXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`endif

// File: hdl/gss_pkg.sv
// shared types and constants for the gauss-seidel solver
package gss_pkg;
    localparam int MAX_UNKNOWNS_DEF  = 64;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [1:0] CMD_WRITE_COEF = 2'd0;
    localparam logic [1:0] CMD_WRITE_RHS  = 2'd1;
    localparam logic [1:0] CMD_SOLVE      = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_UNKNOWNS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SWEEPS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GUESS    = 2'd2;

    localparam logic [6:0]  UNKNOWNS_RESET = 7'd49;
    localparam logic [15:0] SWEEPS_RESET   = 16'd300;
    localparam logic [31:0] GUESS_RESET    = 32'd196608;

    typedef struct packed {
        logic [1:0]         command;
        logic [5:0]         row;
        logic [5:0]         col;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic [5:0]         index;
        logic signed [31:0] solution;
        logic               zero_divisor;
        logic               last;
    } out_item_t;

    // divider handshake between sequencer and divider
    typedef struct packed {
        logic               start;
        logic signed [63:0] num;
        logic signed [31:0] den;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic signed [31:0] quot;
    } div_rsp_t;
endpackage

// File: hdl/gss_divider.sv
// radix-2 restoring divider, 64 by 32 bits, truncating, saturated to 32 bits
module gss_divider
(
    input  logic              clk,
    input  logic              rst_n,
    input  gss_pkg::div_req_t req,
    output gss_pkg::div_rsp_t rsp
);
    logic [63:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [31:0] dmag_reg, dmag_next;
    logic        neg_reg, neg_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] shifted;
    logic [64:0] trial;
    logic [31:0] sat_q;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[63]};
        trial = shifted - {33'd0, dmag_reg};
        rem_next = rem_reg;
        quo_next = quo_reg;
        dmag_next = dmag_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next = 64'd0;
            quo_next = req.num[63] ? 64'd0 - 64'(req.num) : 64'(req.num);
            dmag_next = req.den[31] ? 32'd0 - 32'(req.den) : 32'(req.den);
            neg_next = req.num[63] ^ req.den[31];
            cnt_next = 7'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[64])
            begin
                rem_next = trial[63:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[63:0];
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        if (neg_reg)
            sat_q = (quo_reg >= 64'h8000_0000) ? 32'h8000_0000 : 32'd0 - quo_reg[31:0];
        else
            sat_q = (quo_reg > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo_reg[31:0];
    end

    assign rsp.done = done_reg;
    assign rsp.quot = sat_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= 7'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dmag_reg <= dmag_next;
        neg_reg <= neg_next;
    end
endmodule

// File: hdl/gauss_seidel_solver_top.sv
// gauss-seidel solver top level: stores, sequencer, shared multiply-accumulate
// channel    dir   handshake          payload
// in         in    in_valid/in_stall  gss_pkg::in_item_t
// out        out   out_valid/out_stall gss_pkg::out_item_t
// cfg        in    cfg_we             cfg_idx, cfg_data
// a write command is taken only while idle; a solve first loads the guess into all
// MAX_UNKNOWNS entries, then sweeps on the single multiply-accumulate unit (one product
// per cycle, one memory read port) and the 64-step divider, then outputs each unknown
// after reset a clearing pass over 2^(2*clog2(MAX_UNKNOWNS)) addresses (4096 by default)
// zeroes the matrix and rhs memories while in_stall stays high
// results wait in an output register; a stalled result holds the sequencer
`include "gauss_seidel_solver_top_macros.svh"
module gauss_seidel_solver_top
#(
    parameter int MAX_UNKNOWNS  = gss_pkg::MAX_UNKNOWNS_DEF,
    parameter int FRACTION_BITS = gss_pkg::FRACTION_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  gss_pkg::in_item_t                   in_item,
    output logic                                out_valid,
    input  logic                                out_stall,
    output gss_pkg::out_item_t                  out_item,
    input  logic                                cfg_we,
    input  logic [gss_pkg::CFG_IDX_W-1:0]       cfg_idx,
    input  logic [gss_pkg::CFG_DATA_W-1:0]      cfg_data
);
    localparam int IW = $clog2(MAX_UNKNOWNS);
    localparam int AW = 2 * IW;
    localparam int DEPTH = 1 << AW;
    localparam logic [IW-1:0] TOP_IDX = IW'(MAX_UNKNOWNS - 1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_INIT, S_ROW, S_MAC, S_MACW, S_NUM, S_DIV,
        S_DIVW, S_RDRES, S_OUT
    } state_t;

    state_t state_reg;
    logic [AW-1:0] clr_reg;
    logic [6:0]    n_cfg_reg;
    logic [15:0]   sweeps_cfg_reg;
    logic [31:0]   guess_reg;
    logic [IW-1:0] i_reg, j_reg;
    logic [15:0]   s_reg;
    logic [IW-1:0] nm1_reg;
    logic signed [63:0] acc_reg;
    logic signed [31:0] diag_reg;
    logic          out_valid_reg;
    gss_pkg::out_item_t out_reg;
    logic signed [63:0] prod_reg;
    logic          prod_v_reg;
    logic          mac_v_reg;

    logic signed [31:0] mat_mem [DEPTH];
    logic signed [31:0] rhs_mem [MAX_UNKNOWNS];
    logic signed [31:0] x_mem   [MAX_UNKNOWNS];
    logic signed [31:0] mat_rd_reg, x_rd_reg, rhs_rd_reg;

    gss_pkg::div_req_t div_req;
    gss_pkg::div_rsp_t div_rsp;

    logic in_acc;
    assign in_stall = (state_reg != S_IDLE);
    assign in_acc = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_item = out_reg;

    logic [6:0] n_eff;
    always_comb
    begin
        n_eff = n_cfg_reg;
        if (n_eff == 7'd0) n_eff = 7'd1;
        if (n_eff > 7'(MAX_UNKNOWNS)) n_eff = 7'(MAX_UNKNOWNS);
    end

    // memory write port
    logic          mat_we, x_we;
    logic [AW-1:0] mat_wa;
    logic [IW-1:0] x_wa;
    logic signed [31:0] mat_wd, x_wd;
    logic [AW-1:0] mat_ra;
    logic [IW-1:0] x_ra;
    logic          row_ok, col_ok;

    assign row_ok = 32'(in_item.row) < 32'(MAX_UNKNOWNS);
    assign col_ok = 32'(in_item.col) < 32'(MAX_UNKNOWNS);

    always_comb
    begin
        mat_we = 1'b0;
        mat_wa = {in_item.row[IW-1:0], in_item.col[IW-1:0]};
        mat_wd = in_item.value;
        if (state_reg == S_CLEAR)
        begin
            mat_we = 1'b1;
            mat_wa = clr_reg;
            mat_wd = 32'sd0;
        end
        else if (in_acc && in_item.command == gss_pkg::CMD_WRITE_COEF && row_ok && col_ok)
            mat_we = 1'b1;
    end

    logic signed [63:0] rhs_sh, num_val, acc_sum;
    logic signed [64:0] sum_w, num_w;
    assign sum_w = 65'(acc_reg) + 65'(prod_reg);
    assign acc_sum = (sum_w[64] != sum_w[63]) ?
        (sum_w[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF) : sum_w[63:0];
    assign rhs_sh = 64'(rhs_rd_reg) <<< FRACTION_BITS;
    assign num_w = 65'(rhs_sh) - 65'(acc_reg);
    assign num_val = (num_w[64] != num_w[63]) ?
        (num_w[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF) : num_w[63:0];

    // a zero diagonal leaves the unknown unchanged
    always_comb
    begin
        x_we = 1'b0;
        x_wa = i_reg;
        x_wd = div_rsp.quot;
        if (state_reg == S_INIT)
        begin
            x_we = 1'b1;
            x_wa = j_reg;
            x_wd = guess_reg;
        end
        else if (state_reg == S_DIVW && div_rsp.done && diag_reg != 32'sd0)
            x_we = 1'b1;
    end

    assign mat_ra = (state_reg == S_ROW || state_reg == S_RDRES) ? {i_reg, i_reg}
                                                                 : {i_reg, j_reg};
    assign x_ra = (state_reg == S_RDRES) ? i_reg : j_reg;

    // rhs store: cleared by the same pass as the matrix
    always_ff @(posedge clk)
    begin
        if (mat_we) mat_mem[mat_wa] <= mat_wd;
        mat_rd_reg <= mat_mem[mat_ra];
        if (x_we) x_mem[x_wa] <= x_wd;
        x_rd_reg <= x_mem[x_ra];
        if (state_reg == S_CLEAR && clr_reg < AW'(MAX_UNKNOWNS))
            rhs_mem[clr_reg[IW-1:0]] <= 32'sd0;
        else if (in_acc && in_item.command == gss_pkg::CMD_WRITE_RHS && row_ok)
            rhs_mem[in_item.row[IW-1:0]] <= in_item.value;
        rhs_rd_reg <= rhs_mem[i_reg];
    end

    assign div_req.start = (state_reg == S_DIV);
    assign div_req.num = num_val;
    assign div_req.den = diag_reg;

    gss_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    logic mac_issue;
    assign mac_issue = (state_reg == S_MAC) && (j_reg != i_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            n_cfg_reg <= gss_pkg::UNKNOWNS_RESET;
            sweeps_cfg_reg <= gss_pkg::SWEEPS_RESET;
            guess_reg <= gss_pkg::GUESS_RESET;
            i_reg <= '0;
            j_reg <= '0;
            s_reg <= '0;
            nm1_reg <= '0;
            out_valid_reg <= 1'b0;
            mac_v_reg <= 1'b0;
            prod_v_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx)
                    gss_pkg::REG_UNKNOWNS: n_cfg_reg <= cfg_data[6:0];
                    gss_pkg::REG_SWEEPS:   sweeps_cfg_reg <= cfg_data[15:0];
                    gss_pkg::REG_GUESS:    guess_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            mac_v_reg <= mac_issue;
            prod_v_reg <= mac_v_reg;
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == AW'(DEPTH - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_acc && in_item.command == gss_pkg::CMD_SOLVE)
                    begin
                        nm1_reg <= IW'(n_eff - 7'd1);
                        j_reg <= '0;
                        s_reg <= '0;
                        state_reg <= S_INIT;
                    end
                end
                S_INIT:
                begin
                    j_reg <= j_reg + 1'b1;
                    if (j_reg == TOP_IDX)
                    begin
                        i_reg <= '0;
                        if (sweeps_cfg_reg == 16'd0)
                            state_reg <= S_RDRES;
                        else
                            state_reg <= S_ROW;
                    end
                end
                S_ROW:
                begin
                    j_reg <= '0;
                    state_reg <= S_MAC;
                end
                S_MAC:
                begin
                    j_reg <= j_reg + 1'b1;
                    if (j_reg == nm1_reg)
                        state_reg <= S_MACW;
                end
                S_MACW:
                    state_reg <= S_NUM;
                S_NUM:
                    state_reg <= S_DIV;
                S_DIV:
                    state_reg <= S_DIVW;
                S_DIVW:
                begin
                    if (div_rsp.done)
                    begin
                        if (i_reg == nm1_reg)
                        begin
                            i_reg <= '0;
                            s_reg <= s_reg + 16'd1;
                            if (s_reg + 16'd1 == sweeps_cfg_reg)
                                state_reg <= S_RDRES;
                            else
                                state_reg <= S_ROW;
                        end
                        else
                        begin
                            i_reg <= i_reg + 1'b1;
                            state_reg <= S_ROW;
                        end
                    end
                end
                S_RDRES:
                begin
                    if (!out_valid_reg || !out_stall)
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    out_valid_reg <= 1'b1;
                    if (i_reg == nm1_reg)
                        state_reg <= S_IDLE;
                    else
                    begin
                        i_reg <= i_reg + 1'b1;
                        state_reg <= S_RDRES;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // product, accumulator, diagonal and output register datapath
    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(mat_rd_reg) * 64'(x_rd_reg);
        if (state_reg == S_ROW)
            acc_reg <= 64'sd0;
        else if (prod_v_reg)
            acc_reg <= acc_sum;
        if (state_reg == S_MAC && j_reg == '0)
            diag_reg <= mat_rd_reg;
        if (state_reg == S_OUT)
        begin
            out_reg.index <= 6'(i_reg);
            out_reg.solution <= x_rd_reg;
            out_reg.zero_divisor <= (mat_rd_reg == 32'sd0);
            out_reg.last <= (i_reg == nm1_reg);
        end
    end

    `GS_ASSERT_IMP(a_stall_busy, clk, rst_n, state_reg != S_IDLE, in_stall,
        "input taken while busy")
    `GS_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(out_item), "stalled result changed")
    `GS_ASSERT_IMP(a_div_idle, clk, rst_n, div_req.start, state_reg == S_DIV,
        "divider started outside divide step")
    `GS_ASSERT_NXT(a_solve_starts, clk, rst_n,
        in_valid && !in_stall && in_item.command == gss_pkg::CMD_SOLVE,
        state_reg == S_INIT, "solve did not start")
endmodule

// File: dv/tb_top.sv
// testbench for the gauss-seidel solver: queued driver, self-checking monitor
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NMAX = 64;
    localparam int FRAC = 16;
    localparam int CYCLE_LIMIT = 3000000;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    gss_pkg::in_item_t in_item = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    gss_pkg::out_item_t out_item;
    logic cfg_we = 1'b0;
    logic [gss_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
    logic [gss_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    gauss_seidel_solver_top uut
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // solver image
    logic signed [31:0] coef_mem [NMAX*NMAX];
    logic signed [31:0] rhs_mem [NMAX];
    logic signed [31:0] x_mem [NMAX];
    logic [6:0] n_reg = gss_pkg::UNKNOWNS_RESET;
    logic [15:0] sweeps_reg = gss_pkg::SWEEPS_RESET;
    logic signed [31:0] guess_reg = gss_pkg::GUESS_RESET;

    gss_pkg::in_item_t cmd_q [$];
    gss_pkg::out_item_t solution_q [$];
    int pushed = 0;
    int accepted = 0;
    int errors = 0;
    int cycles = 0;
    int in_gap = 0;
    int out_gap = 0;
    bit calm = 0;

    initial
    begin
        for (int k = 0; k < NMAX*NMAX; k++) coef_mem[k] = '0;
        for (int k = 0; k < NMAX; k++)
        begin
            rhs_mem[k] = '0;
            x_mem[k] = '0;
        end
    end

    function automatic longint sat_add(longint a, longint b);
        longint r;
        r = a + b;
        if (a[63] == b[63] && r[63] != a[63])
            return a[63] ? 64'sh8000000000000000 : 64'sh7fffffffffffffff;
        return r;
    endfunction

    function automatic longint sat_sub(longint a, longint b);
        longint r;
        r = a - b;
        if (a[63] != b[63] && r[63] != a[63])
            return a[63] ? 64'sh8000000000000000 : 64'sh7fffffffffffffff;
        return r;
    endfunction

    function automatic logic signed [31:0] div_sat(longint num, logic signed [31:0] den);
        logic [63:0] mn;
        logic [63:0] md;
        logic [63:0] q;
        longint dl;
        dl = den;
        mn = num[63] ? 64'(-num) : 64'(num);
        md = dl[63] ? 64'(-dl) : 64'(dl);
        q = mn / md;
        if (num[63] ^ den[31])
        begin
            if (q >= 64'h80000000) return 32'sh80000000;
            return -$signed(q[31:0]);
        end
        if (q > 64'h7fffffff) return 32'sh7fffffff;
        return q[31:0];
    endfunction

    task automatic solve_system();
        int n;
        longint acc;
        longint num;
        logic signed [31:0] d;
        gss_pkg::out_item_t r;
        n = n_reg;
        if (n < 1) n = 1;
        if (n > NMAX) n = NMAX;
        for (int i = 0; i < NMAX; i++) x_mem[i] = guess_reg;
        for (int s = 0; s < sweeps_reg; s++)
            for (int i = 0; i < n; i++)
            begin
                acc = 0;
                for (int j = 0; j < n; j++)
                    if (j != i)
                        acc = sat_add(acc, longint'(coef_mem[i*NMAX+j]) * longint'(x_mem[j]));
                d = coef_mem[i*NMAX+i];
                if (d != 0)
                begin
                    num = sat_sub(longint'(rhs_mem[i]) <<< FRAC, acc);
                    x_mem[i] = div_sat(num, d);
                end
            end
        for (int i = 0; i < n; i++)
        begin
            r.index = i[5:0];
            r.solution = x_mem[i];
            r.zero_divisor = (coef_mem[i*NMAX+i] == 0);
            r.last = (i == n - 1);
            solution_q.push_back(r);
        end
    endtask

    task automatic apply_cmd(gss_pkg::in_item_t it);
        case (it.command)
            gss_pkg::CMD_WRITE_COEF: coef_mem[int'(it.row)*NMAX + int'(it.col)] = it.value;
            gss_pkg::CMD_WRITE_RHS: rhs_mem[it.row] = it.value;
            gss_pkg::CMD_SOLVE: solve_system();
            default: ;
        endcase
    endtask

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (in_valid && in_stall)
            ;
        else
        begin
            if (in_valid)
            begin
                apply_cmd(in_item);
                accepted++;
            end
            if (in_gap > 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (cmd_q.size() > 0)
            begin
                in_item <= cmd_q.pop_front();
                in_valid <= 1'b1;
                in_gap = pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("%0t timeout", $time);
                $display("Verification failed");
                $finish;
            end
            else
            begin
                if (out_valid && !out_stall)
                begin
                    if (solution_q.size() == 0)
                    begin
                        $display("%0t unexpected result: expected none, actual %p", $time,
                                 out_item);
                        errors++;
                    end
                    else if (out_item !== solution_q[0])
                    begin
                        $display("%0t mismatch: expected %p, actual %p", $time,
                                 solution_q[0], out_item);
                        errors++;
                        void'(solution_q.pop_front());
                    end
                    else
                        void'(solution_q.pop_front());
                end
                if (calm)
                begin
                    out_gap = 0;
                    out_stall <= 1'b0;
                end
                else if (out_gap > 0)
                begin
                    out_gap--;
                    out_stall <= 1'b1;
                end
                else
                begin
                    out_gap = pick_gap();
                    out_stall <= (out_gap > 0);
                    if (out_gap > 0) out_gap--;
                end
            end
        end
    end

    task automatic push_cmd(logic [1:0] c, int r, int cl, logic signed [31:0] v);
        gss_pkg::in_item_t it;
        it.command = c;
        it.row = r[5:0];
        it.col = cl[5:0];
        it.value = v;
        cmd_q.push_back(it);
        pushed++;
    endtask

    task automatic wait_idle();
        while (accepted != pushed || solution_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [gss_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            gss_pkg::REG_UNKNOWNS: n_reg = data[6:0];
            gss_pkg::REG_SWEEPS: sweeps_reg = data[15:0];
            gss_pkg::REG_GUESS: guess_reg = data;
            default: ;
        endcase
    endtask

    task automatic set_regs(int n, int sw, logic [31:0] g);
        write_reg(gss_pkg::REG_UNKNOWNS, n);
        write_reg(gss_pkg::REG_SWEEPS, sw);
        write_reg(gss_pkg::REG_GUESS, g);
    endtask

    function automatic logic signed [31:0] rand_value(bit diag);
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return 32'sh7fffffff;
        if (r < 10) return 32'sh80000000;
        if (r < 15) return 0;
        if (r < 35) return $urandom();
        if (diag) return $signed($urandom_range(0, 2)) * 2 - 1 <<< 20;
        return $signed($urandom_range(0, 8 << 16)) - (4 << 16);
    endfunction

    initial
    begin
        int n;
        int k;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: small system, extremes, unused command, zero diagonal
        push_cmd(gss_pkg::CMD_WRITE_COEF, 0, 0, 2 << 16);
        push_cmd(gss_pkg::CMD_WRITE_COEF, 0, 1, 1 << 16);
        push_cmd(gss_pkg::CMD_WRITE_COEF, 1, 0, 1 << 16);
        push_cmd(gss_pkg::CMD_WRITE_COEF, 1, 1, 4 << 16);
        push_cmd(gss_pkg::CMD_WRITE_RHS, 0, 0, 3 << 16);
        push_cmd(gss_pkg::CMD_WRITE_RHS, 1, 63, 5 << 16);
        push_cmd(gss_pkg::CMD_WRITE_COEF, 63, 63, 32'sh7fffffff);
        push_cmd(gss_pkg::CMD_WRITE_RHS, 63, 0, 32'sh80000000);
        push_cmd(CMD_UNUSED, 63, 63, -1);
        wait_idle();
        set_regs(3, 3, 0);
        push_cmd(gss_pkg::CMD_SOLVE, 0, 0, 0);
        push_cmd(gss_pkg::CMD_WRITE_COEF, 2, 0, 32'sh80000000);
        push_cmd(gss_pkg::CMD_WRITE_COEF, 0, 2, 32'sh7fffffff);
        push_cmd(gss_pkg::CMD_WRITE_RHS, 2, 2, 32'sh7fffffff);
        push_cmd(gss_pkg::CMD_SOLVE, 63, 63, -1);
        wait_idle();
        set_regs(0, 0, 32'h80000000);
        push_cmd(gss_pkg::CMD_SOLVE, 0, 0, 0);
        wait_idle();
        set_regs(2, 7, 32'h7fffffff);
        push_cmd(gss_pkg::CMD_SOLVE, 0, 0, 0);
        push_cmd(gss_pkg::CMD_WRITE_COEF, 0, 0, 1);
        push_cmd(gss_pkg::CMD_WRITE_COEF, 1, 1, -1);
        push_cmd(gss_pkg::CMD_SOLVE, 0, 0, 0);
        wait_idle();
        set_regs(64, 1, $urandom());
        push_cmd(gss_pkg::CMD_SOLVE, 0, 0, 0);
        wait_idle();
        write_reg(gss_pkg::REG_SWEEPS, 65535);
        set_regs(127, 1, 32'hffff0000);
        push_cmd(gss_pkg::CMD_SOLVE, 0, 0, 0);
        wait_idle();

        // random phases
        while (pushed < 250)
        begin
            calm = ($urandom_range(0, 3) == 0);
            n = $urandom_range(1, 8);
            set_regs(($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) % 9 : n,
                     $urandom_range(0, 5), rand_value(0));
            n = (n_reg == 0) ? 1 : n_reg;
            k = $urandom_range(10, 30);
            for (int m = 0; m < k; m++)
            begin
                int r;
                r = $urandom_range(0, 99);
                if (r < 4)
                    push_cmd(CMD_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63),
                             $urandom());
                else if (r < 12)
                    push_cmd(gss_pkg::CMD_SOLVE, $urandom_range(0, 63), $urandom_range(0, 63),
                             $urandom());
                else if (r < 18)
                    push_cmd(gss_pkg::CMD_WRITE_COEF, $urandom_range(0, 63),
                             $urandom_range(0, 63), $urandom());
                else if (r < 35)
                    push_cmd(gss_pkg::CMD_WRITE_RHS, $urandom_range(0, n - 1),
                             $urandom_range(0, 63), rand_value(0));
                else
                begin
                    int i;
                    int j;
                    i = $urandom_range(0, n - 1);
                    j = $urandom_range(0, n - 1);
                    if ($urandom_range(0, 2) == 0) j = i;
                    push_cmd(gss_pkg::CMD_WRITE_COEF, i, j, rand_value(i == j));
                end
            end
            push_cmd(gss_pkg::CMD_SOLVE, 0, 0, 0);
            wait_idle();
        end

        calm = 0;
        repeat (50) @(posedge clk);
        if (errors == 0 && solution_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
